// File: src/rmtd_pkg.sv
// Package with the types, constants and register indexes of the rate-monotonic tick dispatcher.
package rmtd_pkg;

  localparam int TASK_SLOTS_DEF = 4;
  localparam int PERIOD_REGS    = 4;
  localparam int PERIOD_W       = 16;
  localparam int TIME_W         = 32;
  localparam int TICKS_W        = 32;
  localparam int PEND_W         = 8;
  localparam int ACTIVE_W       = 3;
  localparam int RUN_SLOT_W     = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int BIT_CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TASKS = CFG_IDX_W'(PERIOD_REGS);

  localparam logic       OP_TICK = 1'b0;
  localparam logic       OP_DONE = 1'b1;

  localparam logic [PEND_W-1:0]  PEND_MAX  = '1;
  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PICK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  run_valid;
    logic [RUN_SLOT_W-1:0] run_slot;
    logic [TICKS_W-1:0]    run_ticks;
    logic                  done_fault;
  } result_t;

endpackage

// File: src/rmtd_if.sv
// Handshake interfaces that carry the input words and the result words of the dispatcher.
interface rmtd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [rmtd_pkg::TIME_W-1:0]  time_now;

  modport source (output valid, output operation, output time_now, input ready);
  modport sink   (input valid, input operation, input time_now, output ready);
endinterface

interface rmtd_out_if;
  logic                              valid;
  logic                              ready;
  logic                              run_valid;
  logic [rmtd_pkg::RUN_SLOT_W-1:0]   run_slot;
  logic [rmtd_pkg::TICKS_W-1:0]      run_ticks;
  logic                              done_fault;

  modport source (output valid, output run_valid, output run_slot, output run_ticks,
                  output done_fault, input ready);
  modport sink   (input valid, input run_valid, input run_slot, input run_ticks,
                  input done_fault, output ready);
endinterface

// File: src/rate_monotonic_tick_dispatch.sv
// Top level of the rate-monotonic tick dispatcher with its shared restoring modulo unit.
// A done word goes from acceptance straight to the output state; a tick word runs the modulo
// unit over each active slot in turn, one modulo bit per cycle for each active period, then picks.
// Input is ready again once the result register loads, and a result held back stalls the next
// word.
// Synchronous active-low reset: counters and active tasks zero, periods one, no current slot.
module rate_monotonic_tick_dispatch #(
  parameter int TASK_SLOTS = rmtd_pkg::TASK_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rmtd_in_if.sink                          in_chan,
  rmtd_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [rmtd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmtd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = $clog2(TASK_SLOTS + 1);
  localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(TASK_SLOTS);

  logic [rmtd_pkg::PERIOD_W-1:0] period_r [TASK_SLOTS];
  logic [rmtd_pkg::PERIOD_W-1:0] period_nxt [TASK_SLOTS];
  logic [rmtd_pkg::ACTIVE_W-1:0] active_r, active_nxt;
  logic [rmtd_pkg::PEND_W-1:0]   pend_r [TASK_SLOTS];
  logic [rmtd_pkg::PEND_W-1:0]   pend_nxt [TASK_SLOTS];
  logic [rmtd_pkg::TICKS_W-1:0]  exec_r [TASK_SLOTS];
  logic [rmtd_pkg::TICKS_W-1:0]  exec_nxt [TASK_SLOTS];
  logic [SLOT_W-1:0]             cur_r, cur_nxt;

  rmtd_pkg::state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [rmtd_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [rmtd_pkg::PERIOD_W-1:0] rem_r, rem_nxt;
  logic [rmtd_pkg::TIME_W-1:0]   time_r, time_nxt;
  logic [rmtd_pkg::TIME_W-1:0]   shift_r, shift_nxt;
  rmtd_pkg::result_t             res_r, res_nxt;
  rmtd_pkg::result_t             out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [rmtd_pkg::ACTIVE_W-1:0] n_act;
  logic [IDX_W-1:0]              slot_idx;
  logic [IDX_W-1:0]              cur_idx;
  logic [rmtd_pkg::PERIOD_W:0]   rem_sh;
  logic [rmtd_pkg::PERIOD_W:0]   rem_sub;
  logic [rmtd_pkg::PERIOD_W-1:0] rem_step;
  logic                          found;
  logic [IDX_W-1:0]              sel;
  logic [rmtd_pkg::TICKS_W-1:0]  sel_ticks;
  logic                          out_free;

  assign n_act    = (active_r > rmtd_pkg::ACTIVE_W'(TASK_SLOTS))
                    ? rmtd_pkg::ACTIVE_W'(TASK_SLOTS) : active_r;
  assign slot_idx = slot_r[IDX_W-1:0];
  assign cur_idx  = cur_r[IDX_W-1:0];
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready       = (state_r == rmtd_pkg::ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.run_valid  = out_r.run_valid;
  assign out_chan.run_slot   = out_r.run_slot;
  assign out_chan.run_ticks  = out_r.run_ticks;
  assign out_chan.done_fault = out_r.done_fault;

  // Restoring modulo step: one remainder bit per cycle.
  always_comb begin
    rem_sh   = {rem_r, shift_r[rmtd_pkg::TIME_W-1]};
    rem_sub  = rem_sh - {1'b0, period_r[slot_idx]};
    rem_step = (rem_sh >= {1'b0, period_r[slot_idx]}) ? rem_sub[rmtd_pkg::PERIOD_W-1:0]
                                                      : rem_sh[rmtd_pkg::PERIOD_W-1:0];
  end

  // Highest-priority active slot with releases pending.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if ((rmtd_pkg::ACTIVE_W'(i) < n_act) && (pend_r[i] != '0)) begin
        found = 1'b1;
        sel   = IDX_W'(i);
      end
    end
    sel_ticks = (exec_r[sel] == rmtd_pkg::TICKS_MAX) ? exec_r[sel] : exec_r[sel] + 1'b1;
  end

  always_comb begin
    period_nxt    = period_r;
    active_nxt    = active_r;
    pend_nxt      = pend_r;
    exec_nxt      = exec_r;
    cur_nxt       = cur_r;
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    time_nxt      = time_r;
    shift_nxt     = shift_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if ((i < rmtd_pkg::PERIOD_REGS) && (cfg_index == rmtd_pkg::CFG_IDX_W'(i))) begin
          period_nxt[i] = cfg_data;
        end
      end
      if (cfg_index == rmtd_pkg::REG_ACTIVE_TASKS) begin
        active_nxt = cfg_data[rmtd_pkg::ACTIVE_W-1:0];
      end
    end

    case (state_r)
      rmtd_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          res_nxt = '0;
          if (in_chan.operation == rmtd_pkg::OP_TICK) begin
            time_nxt    = in_chan.time_now;
            shift_nxt   = in_chan.time_now;
            rem_nxt     = '0;
            bit_cnt_nxt = '0;
            slot_nxt    = '0;
            state_nxt   = rmtd_pkg::ST_DIVIDE;
          end else begin
            if (cur_r >= NONE_SLOT) begin
              res_nxt.done_fault = 1'b1;
            end else begin
              if ((rmtd_pkg::ACTIVE_W'(cur_r) < n_act) && (pend_r[cur_idx] != '0)) begin
                pend_nxt[cur_idx] = pend_r[cur_idx] - 1'b1;
              end
              cur_nxt = NONE_SLOT;
            end
            state_nxt = rmtd_pkg::ST_OUT;
          end
        end
      end
      rmtd_pkg::ST_DIVIDE: begin
        if (rmtd_pkg::ACTIVE_W'(slot_r) >= n_act) begin
          state_nxt = rmtd_pkg::ST_PICK;
        end else begin
          rem_nxt     = rem_step;
          shift_nxt   = {shift_r[rmtd_pkg::TIME_W-2:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          if (bit_cnt_r == '1) begin
            if ((period_r[slot_idx] != '0) && (rem_step == '0) &&
                (pend_r[slot_idx] != rmtd_pkg::PEND_MAX)) begin
              pend_nxt[slot_idx] = pend_r[slot_idx] + 1'b1;
            end
            rem_nxt   = '0;
            shift_nxt = time_r;
            slot_nxt  = slot_r + 1'b1;
          end
        end
      end
      rmtd_pkg::ST_PICK: begin
        if (found) begin
          cur_nxt           = SLOT_W'(sel);
          exec_nxt[sel]     = sel_ticks;
          res_nxt.run_valid = 1'b1;
          res_nxt.run_slot  = rmtd_pkg::RUN_SLOT_W'(sel);
          res_nxt.run_ticks = sel_ticks;
        end
        state_nxt = rmtd_pkg::ST_OUT;
      end
      rmtd_pkg::ST_OUT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = rmtd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmtd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_r[i] <= rmtd_pkg::PERIOD_W'(1);
        pend_r[i]   <= '0;
        exec_r[i]   <= '0;
      end
      active_r    <= '0;
      cur_r       <= NONE_SLOT;
      state_r     <= rmtd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      pend_r      <= pend_nxt;
      exec_r      <= exec_nxt;
      active_r    <= active_nxt;
      cur_r       <= cur_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rem_r     <= rem_nxt;
    time_r    <= time_nxt;
    shift_r   <= shift_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  a_word_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.run_valid && out_r.done_fault))
    else $error("A result word carries both a selection and a done fault.");

  a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.run_valid) |-> (out_r.run_ticks != '0))
    else $error("A selected slot reports a zero executed tick count.");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= NONE_SLOT)
    else $error("The current slot holds a value beyond the none marker.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("The dispatcher took a new word while still working on one.");

endmodule
